>>> design/ccpf_pkg.sv
// Shared types and constants for the CRC-16 command packet framer.
package ccpf_pkg;

  // Kind of work queued between the front and the back
  typedef enum logic [1:0] {
    CMD_HDR,
    CMD_HDR_ERR,
    CMD_DATA
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  opcode;
    logic [7:0]  first_param;
    logic [15:0] second_param;
    logic [7:0]  data_len;
    logic [7:0]  data_byte;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic not_empty;
  } q_stat_t;

  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW    = $clog2(QDEPTH);

  localparam int unsigned PKT_OVERHEAD = 8;
  localparam logic [7:0]  WORD_ADDR_CMD = 8'h03;
  localparam logic [15:0] CRC_POLY      = 16'h8005;

  localparam logic [1:0] ERR_OK      = 2'd0;
  localparam logic [1:0] ERR_LEN     = 2'd1;
  localparam logic [1:0] ERR_NOFRAME = 2'd2;

endpackage

>>> design/ccpf_front.sv
// Front end: accepts input items and classifies them into queued commands.
module ccpf_front #(
  parameter int unsigned MAX_PACKET_BYTES = 255
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_req_type,
  input  logic [7:0]         in_opcode,
  input  logic [7:0]         in_first_param,
  input  logic [15:0]        in_second_param,
  input  logic [7:0]         in_data_len,
  input  logic [7:0]         in_data_byte,
  input  ccpf_pkg::q_stat_t  q_stat,
  output logic               q_push,
  output ccpf_pkg::cmd_t     q_cmd
);
  import ccpf_pkg::*;

  localparam logic [7:0] LEN_LIMIT = 8'(MAX_PACKET_BYTES - PKT_OVERHEAD);

  assign in_ready = !q_stat.full;
  assign q_push   = in_valid && !q_stat.full;

  always_comb begin
    if (in_req_type) begin
      q_cmd.kind = CMD_DATA;
    end else if (in_data_len > LEN_LIMIT) begin
      q_cmd.kind = CMD_HDR_ERR;
    end else begin
      q_cmd.kind = CMD_HDR;
    end
    q_cmd.opcode       = in_opcode;
    q_cmd.first_param  = in_first_param;
    q_cmd.second_param = in_second_param;
    q_cmd.data_len     = in_data_len;
    q_cmd.data_byte    = in_data_byte;
  end

endmodule

>>> design/ccpf_queue.sv
// Short command queue between the front end and the back end.
module ccpf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ccpf_pkg::cmd_t     push_cmd,
  input  logic               pop,
  output ccpf_pkg::cmd_t     head,
  output ccpf_pkg::q_stat_t  stat
);
  import ccpf_pkg::*;

  cmd_t           entries_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r;
  logic [QAW-1:0] rd_ptr_r;
  logic [QAW:0]   count_r;

  assign head           = entries_r[rd_ptr_r];
  assign stat.full      = (count_r == (QAW+1)'(QDEPTH));
  assign stat.not_empty = (count_r != '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> design/ccpf_back.sv
// Back end: steps through each command, keeps the CRC, drives the output register.
module ccpf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  ccpf_pkg::cmd_t     head,
  input  ccpf_pkg::q_stat_t  q_stat,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [7:0]         out_frame_byte,
  output logic               out_last,
  output logic               out_frame_end,
  output logic [1:0]         out_error_code
);
  import ccpf_pkg::*;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (b[i] != c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

  cmd_t        cur_r;
  logic        active_r;
  logic [2:0]  step_r;
  logic [15:0] crc_r,  crc_nxt;
  logic [7:0]  left_r, left_nxt;
  logic        open_r, open_nxt;

  logic        ov_r;
  logic [7:0]  obyte_r;
  logic        olast_r, ofend_r;
  logic [1:0]  oerr_r;

  cmd_t        cmd;
  logic [2:0]  step;
  logic        sel_valid, adv, fin;
  logic [7:0]  e_byte;
  logic        e_last, e_fend;
  logic [1:0]  e_err;

  assign cmd       = active_r ? cur_r : head;
  assign step      = active_r ? step_r : 3'd0;
  assign sel_valid = active_r || q_stat.not_empty;
  assign adv       = sel_valid && (!ov_r || out_ready);
  assign q_pop     = adv && !active_r;

  always_comb begin
    e_byte   = '0;
    e_last   = 1'b0;
    e_fend   = 1'b0;
    e_err    = ERR_OK;
    fin      = 1'b0;
    crc_nxt  = crc_r;
    left_nxt = left_r;
    open_nxt = open_r;
    case (cmd.kind)
      CMD_HDR_ERR: begin
        e_last   = 1'b1;
        e_err    = ERR_LEN;
        fin      = 1'b1;
        crc_nxt  = '0;
        left_nxt = '0;
        open_nxt = 1'b0;
      end
      CMD_HDR: begin
        case (step)
          3'd0: begin
            e_byte   = WORD_ADDR_CMD;
            crc_nxt  = '0;
            left_nxt = '0;
            open_nxt = 1'b0;
          end
          3'd1: begin
            e_byte  = 8'(cmd.data_len + 8'(PKT_OVERHEAD - 1));
            crc_nxt = crc_feed(crc_r, e_byte);
          end
          3'd2: begin
            e_byte  = cmd.opcode;
            crc_nxt = crc_feed(crc_r, e_byte);
          end
          3'd3: begin
            e_byte  = cmd.first_param;
            crc_nxt = crc_feed(crc_r, e_byte);
          end
          3'd4: begin
            e_byte  = cmd.second_param[7:0];
            crc_nxt = crc_feed(crc_r, e_byte);
          end
          3'd5: begin
            e_byte  = cmd.second_param[15:8];
            crc_nxt = crc_feed(crc_r, e_byte);
            if (cmd.data_len != '0) begin
              e_last   = 1'b1;
              fin      = 1'b1;
              left_nxt = cmd.data_len;
              open_nxt = 1'b1;
            end
          end
          3'd6: begin
            e_byte = crc_r[7:0];
          end
          default: begin
            e_byte   = crc_r[15:8];
            e_last   = 1'b1;
            e_fend   = 1'b1;
            fin      = 1'b1;
            crc_nxt  = '0;
            left_nxt = '0;
            open_nxt = 1'b0;
          end
        endcase
      end
      CMD_DATA: begin
        case (step)
          3'd0: begin
            if (!open_r) begin
              e_last = 1'b1;
              e_err  = ERR_NOFRAME;
              fin    = 1'b1;
            end else begin
              e_byte   = cmd.data_byte;
              crc_nxt  = crc_feed(crc_r, e_byte);
              left_nxt = left_r - 1'b1;
              if (left_r != 8'd1) begin
                e_last = 1'b1;
                fin    = 1'b1;
              end
            end
          end
          3'd1: begin
            e_byte = crc_r[7:0];
          end
          default: begin
            e_byte   = crc_r[15:8];
            e_last   = 1'b1;
            e_fend   = 1'b1;
            fin      = 1'b1;
            crc_nxt  = '0;
            left_nxt = '0;
            open_nxt = 1'b0;
          end
        endcase
      end
      default: begin
        fin = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      step_r   <= '0;
      crc_r    <= '0;
      left_r   <= '0;
      open_r   <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      if (adv) begin
        crc_r  <= crc_nxt;
        left_r <= left_nxt;
        open_r <= open_nxt;
        ov_r   <= 1'b1;
        if (fin) begin
          active_r <= 1'b0;
        end else begin
          active_r <= 1'b1;
          step_r   <= step + 1'b1;
        end
        if (!active_r) begin
          cur_r <= head;
        end
        obyte_r <= e_byte;
        olast_r <= e_last;
        ofend_r <= e_fend;
        oerr_r  <= e_err;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid      = ov_r;
  assign out_frame_byte = obyte_r;
  assign out_last       = olast_r;
  assign out_frame_end  = ofend_r;
  assign out_error_code = oerr_r;

endmodule

>>> design/crc16_command_packet_framer.sv
// CRC-16 command packet framer: top level joining front end, queue and back end.
// Path: when the back end is idle, an item's first byte goes through the queue write,
//   then the output register.
// Throughput: one output byte per cycle from the back end's sequencer while out_ready does
//   not stall it; a data item emits one byte (three when it closes the frame with its CRC),
//   a header six (eight with an empty payload), a rejected item one.
module crc16_command_packet_framer #(
  parameter int unsigned MAX_PACKET_BYTES = 255
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_req_type,
  input  logic [7:0]  in_opcode,
  input  logic [7:0]  in_first_param,
  input  logic [15:0] in_second_param,
  input  logic [7:0]  in_data_len,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_frame_byte,
  output logic        out_last,
  output logic        out_frame_end,
  output logic [1:0]  out_error_code
);
  import ccpf_pkg::*;

  // Reset: synchronous, active low; clears the queue, the open frame, CRC and output valid.

  // Handshake between the parts: front pushes classified commands, back pops them.
  q_stat_t q_stat;
  logic    q_push;
  logic    q_pop;
  cmd_t    q_cmd;
  cmd_t    q_head;

  // Front end: classify each item (header, oversize header, data byte).
  ccpf_front #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_front (
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_opcode       (in_opcode),
    .in_first_param  (in_first_param),
    .in_second_param (in_second_param),
    .in_data_len     (in_data_len),
    .in_data_byte    (in_data_byte),
    .q_stat          (q_stat),
    .q_push          (q_push),
    .q_cmd           (q_cmd)
  );

  // Queue: decouple intake from the multi-byte header and CRC tail sequences.
  ccpf_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  // Back end: emit bytes, track the open frame and run the CRC.
  ccpf_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (q_head),
    .q_stat         (q_stat),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last),
    .out_frame_end  (out_frame_end),
    .out_error_code (out_error_code)
  );

  // A packet end always closes its item.
  a_fend_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_end |-> out_last)
    else $error("frame end without last");

  // Error results are single zero bytes that never end a packet.
  a_err_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_error_code != ERR_OK) |->
      out_last && !out_frame_end && (out_frame_byte == 8'h00))
    else $error("malformed error result");

  // Never pop an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_stat.not_empty)
    else $error("pop from empty queue");

  // Never push into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("push into full queue");

endmodule

>>> tb/tb_crc16_command_packet_framer.sv
`timescale 1ns / 100ps
// Self-checking testbench for the CRC-16 command packet framer.
module tb_crc16_command_packet_framer;
  import ccpf_pkg::*;

  localparam int unsigned PKT_MAX_BYTES = 255;
  // Longest payload a header may announce before it is rejected
  localparam int unsigned LEN_LIMIT     = PKT_MAX_BYTES - PKT_OVERHEAD;
  localparam logic        REQ_HEADER    = 1'b0;
  localparam logic        REQ_DATA      = 1'b1;
  // Cycles with no handshake on either side before the run is declared hung
  localparam int unsigned STALL_LIMIT   = 3000;
  // Quiet cycles after the last byte, to catch stray output
  localparam int unsigned DRAIN_CYCLES  = 20;
  localparam int unsigned RANDOM_ITEMS  = 160;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last;
    logic       frame_end;
    logic [1:0] error_code;
  } frame_res_t;

  logic        clk             = 1'b0;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_ready;
  logic        in_req_type     = REQ_HEADER;
  logic [7:0]  in_opcode       = 8'h00;
  logic [7:0]  in_first_param  = 8'h00;
  logic [15:0] in_second_param = 16'h0000;
  logic [7:0]  in_data_len     = 8'h00;
  logic [7:0]  in_data_byte    = 8'h00;
  logic        out_valid;
  logic        out_ready       = 1'b0;
  logic [7:0]  out_frame_byte;
  logic        out_last;
  logic        out_frame_end;
  logic [1:0]  out_error_code;

  // Packet bytes the framer still owes us, oldest first
  frame_res_t  packet_bytes_due[$];

  // Shadow framing state
  logic [15:0] crc_run      = 16'h0000;
  logic [7:0]  payload_left = 8'h00;
  logic        frame_live   = 1'b0;

  int unsigned fail_count     = 0;
  int unsigned items_accepted = 0;
  int unsigned burst_left     = 4;
  int unsigned idle_cycles    = 0;
  logic [7:0]  stall_tick     = 8'h00;
  logic [1:0]  stall_mode     = 2'd0;

  crc16_command_packet_framer #(
    .MAX_PACKET_BYTES(PKT_MAX_BYTES)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_opcode      (in_opcode),
    .in_first_param (in_first_param),
    .in_second_param(in_second_param),
    .in_data_len    (in_data_len),
    .in_data_byte   (in_data_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last       (out_last),
    .out_frame_end  (out_frame_end),
    .out_error_code (out_error_code)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Shift one byte into the CRC, LSB first, into a left-shifting register
  function automatic logic [15:0] crc16_add_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (b[i] != c[15]) c = {c[14:0], 1'b0} ^ CRC_POLY;
      else c = {c[14:0], 1'b0};
    end
    return c;
  endfunction

  function automatic void push_result(input logic [7:0] b, input logic lst, input logic fend,
                                      input logic [1:0] err);
    frame_res_t r;
    r.frame_byte = b;
    r.last       = lst;
    r.frame_end  = fend;
    r.error_code = err;
    packet_bytes_due.push_back(r);
  endfunction

  // Emit a byte that the CRC covers
  function automatic void push_covered(input logic [7:0] b, input logic lst);
    crc_run = crc16_add_byte(crc_run, b);
    push_result(b, lst, 1'b0, ERR_OK);
  endfunction

  // Append CRC low then high byte and close the frame
  function automatic void push_crc_tail();
    push_result(crc_run[7:0], 1'b0, 1'b0, ERR_OK);
    push_result(crc_run[15:8], 1'b1, 1'b1, ERR_OK);
    frame_live   = 1'b0;
    payload_left = 8'h00;
    crc_run      = 16'h0000;
  endfunction

  // Work out the packet bytes one accepted item produces
  function automatic void build_packet_bytes(input logic rt, input logic [7:0] op,
                                             input logic [7:0] p1, input logic [15:0] p2,
                                             input logic [7:0] len, input logic [7:0] db);
    if (rt == REQ_HEADER) begin
      // A header always drops whatever frame was open
      frame_live   = 1'b0;
      payload_left = 8'h00;
      crc_run      = 16'h0000;
      if (len > LEN_LIMIT) begin
        push_result(8'h00, 1'b1, 1'b0, ERR_LEN);
        return;
      end
      push_result(WORD_ADDR_CMD, 1'b0, 1'b0, ERR_OK);
      push_covered(len + 8'(PKT_OVERHEAD - 1), 1'b0);
      push_covered(op, 1'b0);
      push_covered(p1, 1'b0);
      push_covered(p2[7:0], 1'b0);
      push_covered(p2[15:8], len != 8'h00);
      if (len == 8'h00) begin
        push_crc_tail();
      end else begin
        payload_left = len;
        frame_live   = 1'b1;
      end
    end else if (!frame_live) begin
      push_result(8'h00, 1'b1, 1'b0, ERR_NOFRAME);
    end else begin
      payload_left = payload_left - 8'd1;
      push_covered(db, payload_left != 8'h00);
      if (payload_left == 8'h00) push_crc_tail();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  // Compare every accepted byte against the oldest expectation
  always @(posedge clk) begin
    frame_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (packet_bytes_due.size() == 0) begin
        $error("unexpected result: frame_byte %02h last %0b frame_end %0b error_code %0d",
               out_frame_byte, out_last, out_frame_end, out_error_code);
        fail_count++;
      end else begin
        want = packet_bytes_due.pop_front();
        if (out_frame_byte !== want.frame_byte) begin
          $error("frame_byte: expected %02h, got %02h", want.frame_byte, out_frame_byte);
          fail_count++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, out_last);
          fail_count++;
        end
        if (out_frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
          fail_count++;
        end
        if (out_error_code !== want.error_code) begin
          $error("error_code: expected %0d, got %0d", want.error_code, out_error_code);
          fail_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: switch among randomly picked stall patterns over the cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stall_tick <= stall_tick + 8'd1;
    if (stall_tick[5:0] == 6'd0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_ready <= 1'b1;                          // no stalls at all
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);   // sparse random stalls
      2'd2: out_ready <= (stall_tick % 3 == 0);         // ready when the tick counter is a multiple of three
      default: out_ready <= (stall_tick[3:0] == 4'd0);  // long stalls
    endcase
  end

  // Hang detector: give up when neither side moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Present one item, hold it until accepted, then predict it.
  // Bursts end with a random gap; valid stays high inside a burst.
  task automatic send_item(input logic rt, input logic [7:0] op, input logic [7:0] p1,
                           input logic [15:0] p2, input logic [7:0] len, input logic [7:0] db);
    int unsigned gap;
    in_valid        <= 1'b1;
    in_req_type     <= rt;
    in_opcode       <= op;
    in_first_param  <= p1;
    in_second_param <= p2;
    in_data_len     <= len;
    in_data_byte    <= db;
    do @(posedge clk); while (!in_ready);
    build_packet_bytes(rt, op, p1, p2, len, db);
    items_accepted++;
    burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 4);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Header item; the unused data byte carries noise
  task automatic send_header(input logic [7:0] op, input logic [7:0] p1, input logic [15:0] p2,
                             input logic [7:0] len);
    send_item(REQ_HEADER, op, p1, p2, len, 8'($urandom));
  endtask

  // Data item; the unused header fields carry noise
  task automatic send_data(input logic [7:0] db);
    send_item(REQ_DATA, 8'($urandom), 8'($urandom), 16'($urandom), 8'($urandom), db);
  endtask

  // Hold off the sender until every owed byte has come out
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (packet_bytes_due.size() != 0) @(posedge clk);
  endtask

  // Field extremes, empty payload, and short complete packets
  task automatic test_directed_packets();
    send_header(8'h00, 8'h00, 16'h0000, 8'd0);   // all-zero header, empty payload
    send_header(8'hFF, 8'hFF, 16'hFFFF, 8'd0);   // all-ones header, empty payload
    send_header(8'h12, 8'h34, 16'h5678, 8'd1);
    send_data(8'h00);                            // single byte closes the frame
    send_header(8'hA5, 8'h5A, 16'h00FF, 8'd3);
    send_data(8'hFF);
    send_data(8'hA5);
    send_data(8'h5A);
  endtask

  // Rejected lengths, stray data and aborted frames
  task automatic test_error_cases();
    send_data(8'hFF);                            // data with no frame open
    send_header(8'h01, 8'h02, 16'h0304, 8'd248); // just over the length limit
    send_header(8'h01, 8'h02, 16'h0304, 8'd255); // largest length field
    send_header(8'h40, 8'h41, 16'hFF00, 8'd2);
    send_data(8'h11);
    // New header aborts the open frame; take the longest legal length
    send_header(8'h7E, 8'h81, 16'h8001, 8'(LEN_LIMIT));
    send_data(8'h22);
    // Too-long header also kills the open frame, so the next data is stray
    send_header(8'h55, 8'hAA, 16'h1234, 8'd250);
    send_data(8'h33);
    send_header(8'hC3, 8'h3C, 16'hBEEF, 8'd1);
    send_data(8'h80);
    send_data(8'h44);                            // frame just closed
  endtask

  // Mostly well-formed packets with random content, some noise and aborts.
  // Pause once halfway until the framer has fully drained.
  task automatic test_random_packets(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned len;
    int unsigned pick;
    bit          paused;
    stop_at = items_accepted + n_items;
    paused  = 1'b0;
    while (items_accepted < stop_at) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
        send_data(8'($urandom));
      end else if (pick == 1) begin
        send_header(8'($urandom), 8'($urandom), 16'($urandom),
                    8'($urandom_range(LEN_LIMIT + 1, 255)));
      end else begin
        // Keep payloads short; now and then a longer one
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 100) : $urandom_range(0, 8);
        send_header(8'($urandom), 8'($urandom), 16'($urandom), 8'(len));
        for (int k = 0; k < len; k++) begin
          if (items_accepted >= stop_at) break;    // item budget spent, leave the frame open
          if ($urandom_range(0, 39) == 0) break;   // leave the frame open for an abort
          send_data(8'($urandom));
        end
      end
      if (!paused && items_accepted + n_items / 2 >= stop_at) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_packets();
    test_error_cases();
    test_random_packets(RANDOM_ITEMS);

    // Drain, then watch a few quiet cycles for stray output
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (packet_bytes_due.size() != 0) begin
      $error("%0d expected results never arrived", packet_bytes_due.size());
      fail_count++;
    end

    if (fail_count == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

>>> crc16_command_packet_framer.f
design/ccpf_pkg.sv
design/ccpf_front.sv
design/ccpf_queue.sv
design/ccpf_back.sv
design/crc16_command_packet_framer.sv
tb/tb_crc16_command_packet_framer.sv
